>>> rtl/page_locality_distance_counter_top_defines.svh
// Assertion macros used by the page locality counter top level.
`ifndef PAGE_LOCALITY_DISTANCE_COUNTER_TOP_DEFINES_SVH
`define PAGE_LOCALITY_DISTANCE_COUNTER_TOP_DEFINES_SVH

// Plain property check on clk, muted while rst_n is low.
`define PLDC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Overlapping implication check on clk, muted while rst_n is low.
`define PLDC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication check on clk, muted while rst_n is low.
`define PLDC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/pldc_pkg.sv
// Types and constants for the page locality distance counter.
package pldc_pkg;

  typedef enum logic [1:0] {
    REQ_SAMPLE = 2'd0,
    REQ_READ   = 2'd1,
    REQ_CLEAR  = 2'd2
  } req_type_t;

  // Configuration register indexes.
  localparam logic CFG_PAGE_SHIFT = 1'b0;
  localparam logic CFG_HIST_DEPTH = 1'b1;

  localparam logic [4:0] PAGE_SHIFT_RST = 5'd12;
  localparam logic [3:0] HIST_DEPTH_RST = 4'd8;

  localparam int ADDR_W  = 32;
  localparam int IDX_W   = 4;
  localparam int MASK_W  = 16;
  localparam int OUT_W   = 32;

  // State update strobes for one beat leaving the input stage.
  typedef struct packed {
    logic sample;
    logic clear;
  } upd_t;

endpackage

>>> rtl/pldc_history.sv
// Page history shift line with per-slot match compare.
module pldc_history #(
  parameter int SLOTS = 16,
  parameter int DEPW  = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  pldc_pkg::upd_t             upd,
  input  logic [pldc_pkg::ADDR_W-1:0] page,
  input  logic [DEPW-1:0]            depth,
  output logic [SLOTS-1:0]           hit
);

  logic [pldc_pkg::ADDR_W-1:0] hist_r   [SLOTS];
  logic [pldc_pkg::ADDR_W-1:0] hist_nxt [SLOTS];

  always_comb begin
    hist_nxt = hist_r;
    hit      = '0;
    if (upd.clear) begin
      hist_nxt = '{default: '0};
    end else if (upd.sample) begin
      hist_nxt[0] = page;
      // slots below the active depth shift up and compare in parallel
      for (int i = 1; i < SLOTS; i++) begin
        if (i < int'(depth)) begin
          hist_nxt[i] = hist_r[i-1];
          hit[i]      = (hist_r[i-1] == page);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r <= '{default: '0};
    end else begin
      hist_r <= hist_nxt;
    end
  end

endmodule

>>> rtl/pldc_counters.sv
// Saturating hit counters, sample counter and counter readout.
module pldc_counters #(
  parameter int SLOTS = 16,
  parameter int CNT_W = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  pldc_pkg::upd_t              upd,
  input  logic [SLOTS-1:0]            hit,
  input  logic [pldc_pkg::IDX_W-1:0]  rd_idx,
  output logic [pldc_pkg::OUT_W-1:0]  rd_value,
  output logic [pldc_pkg::OUT_W-1:0]  total_nxt
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic [CNT_W-1:0] cnt_r   [SLOTS];
  logic [CNT_W-1:0] cnt_nxt [SLOTS];
  logic [CNT_W-1:0] smp_r;
  logic [CNT_W-1:0] smp_nxt;
  logic [IW-1:0]    rd_sel;

  always_comb begin
    cnt_nxt = cnt_r;
    smp_nxt = smp_r;
    if (upd.clear) begin
      cnt_nxt = '{default: '0};
      smp_nxt = '0;
    end else if (upd.sample) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (hit[i] && (cnt_r[i] != '1)) begin
          cnt_nxt[i] = cnt_r[i] + CNT_W'(1);
        end
      end
      if (smp_r != '1) begin
        smp_nxt = smp_r + CNT_W'(1);
      end
    end
  end

  assign total_nxt = pldc_pkg::OUT_W'(smp_nxt);
  assign rd_sel    = IW'(rd_idx);

  always_comb begin
    rd_value = '0;
    if (32'(rd_idx) < 32'(SLOTS)) begin
      rd_value = pldc_pkg::OUT_W'(cnt_r[rd_sel]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '{default: '0};
      smp_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      smp_r <= smp_nxt;
    end
  end

endmodule

>>> rtl/page_locality_distance_counter_top.sv
// An input beat reaches its result beat through the input register and then the result register.
// Throughput: one item per cycle while out_tready allows; history shift, slot compares and
// counter updates are done in one pass between the input register and the result register.
// A full result register with out_tready low back-pressures one more beat into the input stage.
// Reset (rst_n low, synchronous) clears history, hit counters, sample counter and both
// pipeline valids, and loads page_shift = 12 and history_depth = 8.
`include "page_locality_distance_counter_top_defines.svh"

module page_locality_distance_counter_top #(
  parameter int HISTORY_SLOTS = 16,
  parameter int COUNT_BITS    = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  // config write port
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [4:0]  cfg_wdata,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [31:0] address, [35:32] distance_index, [39:36] zero
  input  logic [1:0]  in_tuser,   // [1:0] req_type
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [87:0] out_tdata   // [15:0] hit_mask, [16] sample_taken,
                                  // [48:17] counter_value, [80:49] total_samples, [87:81] zero
);

  localparam int DEPW = (HISTORY_SLOTS > 1) ? $clog2(HISTORY_SLOTS) : 1;

  // config registers
  logic [4:0] page_shift_r;
  logic [3:0] hist_depth_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_shift_r <= pldc_pkg::PAGE_SHIFT_RST;
      hist_depth_r <= pldc_pkg::HIST_DEPTH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        pldc_pkg::CFG_PAGE_SHIFT: page_shift_r <= cfg_wdata;
        pldc_pkg::CFG_HIST_DEPTH: hist_depth_r <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  // input stage
  logic                          s1_valid_r;
  logic [1:0]                    s1_type_r;
  logic [pldc_pkg::ADDR_W-1:0]   s1_addr_r;
  logic [pldc_pkg::IDX_W-1:0]    s1_idx_r;

  // result stage
  logic                          out_valid_r;
  logic [pldc_pkg::MASK_W-1:0]   mask_r;
  logic                          taken_r;
  logic [pldc_pkg::OUT_W-1:0]    value_r;
  logic [pldc_pkg::OUT_W-1:0]    total_r;

  logic                          s2_ready;
  logic                          fire;
  logic                          in_acc;
  logic                          is_sample_ok;
  logic                          is_read;
  pldc_pkg::upd_t                upd;
  logic [pldc_pkg::ADDR_W-1:0]   page;
  logic [DEPW-1:0]               depth_eff;
  logic [HISTORY_SLOTS-1:0]      hit;
  logic [pldc_pkg::OUT_W-1:0]    rd_value;
  logic [pldc_pkg::OUT_W-1:0]    total_nxt;

  assign s2_ready  = !out_valid_r || out_tready;
  assign fire      = s1_valid_r && s2_ready;
  assign in_tready = !s1_valid_r || s2_ready;
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_type_r <= in_tuser;
      s1_addr_r <= in_tdata[31:0];
      s1_idx_r  <= in_tdata[35:32];
    end
  end

  // zero addresses and the upper half of the space are not sampled
  always_comb begin
    is_sample_ok = 1'b0;
    is_read      = 1'b0;
    upd          = '0;
    case (pldc_pkg::req_type_t'(s1_type_r))
      pldc_pkg::REQ_SAMPLE: begin
        is_sample_ok = (s1_addr_r != '0) && !s1_addr_r[pldc_pkg::ADDR_W-1];
        upd.sample   = fire && is_sample_ok;
      end
      pldc_pkg::REQ_READ: begin
        is_read = 1'b1;
      end
      pldc_pkg::REQ_CLEAR: begin
        upd.clear = fire;
      end
      default: ;
    endcase
  end

  assign page = s1_addr_r >> page_shift_r;

  always_comb begin
    if (32'(hist_depth_r) > 32'(HISTORY_SLOTS - 1)) begin
      depth_eff = DEPW'(HISTORY_SLOTS - 1);
    end else begin
      depth_eff = DEPW'(hist_depth_r);
    end
  end

  pldc_history #(
    .SLOTS (HISTORY_SLOTS),
    .DEPW  (DEPW)
  ) u_history (
    .clk   (clk),
    .rst_n (rst_n),
    .upd   (upd),
    .page  (page),
    .depth (depth_eff),
    .hit   (hit)
  );

  pldc_counters #(
    .SLOTS (HISTORY_SLOTS),
    .CNT_W (COUNT_BITS)
  ) u_counters (
    .clk       (clk),
    .rst_n     (rst_n),
    .upd       (upd),
    .hit       (hit),
    .rd_idx    (s1_idx_r),
    .rd_value  (rd_value),
    .total_nxt (total_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      mask_r  <= pldc_pkg::MASK_W'(hit);
      taken_r <= upd.sample;
      value_r <= is_read ? rd_value : '0;
      total_r <= total_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, total_r, value_r, taken_r, mask_r};

  `PLDC_ASSERT_IMP(a_taken_counts, out_valid_r && taken_r, total_r != '0, "sample taken with zero sample count")
  `PLDC_ASSERT_IMP(a_mask_needs_sample, out_valid_r && (mask_r != '0), taken_r, "hit mask set without a sample")
  `PLDC_ASSERT_IMP(a_slot0_no_hit, out_valid_r, !mask_r[0], "slot 0 reported a hit")
  `PLDC_ASSERT_NXT(a_clear_zeroes, upd.clear, (total_r == '0) && (mask_r == '0), "clear left counts")
  `PLDC_ASSERT_IMP(a_stall_blocks, s1_valid_r && out_valid_r && !out_tready, !in_tready, "input taken while both stages full")

endmodule

>>> tb/page_locality_distance_counter_top_test.sv
// Self-checking testbench for the page locality distance counter top level.
`timescale 1ns / 1ps

module page_locality_distance_counter_top_test;

  localparam int HALF_PERIOD    = 4;
  localparam int RESET_CYCLES   = 9;
  localparam int SLOTS          = 16;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int SETTLE_CYCLES  = 4;
  localparam int RANDOM_PHASES  = 6;
  localparam int PHASE_ITEMS    = 170;
  localparam int HOLD_OFF_LEN   = 80;
  localparam int MAX_REPORTS    = 40;

  // Request code that the block must treat as a no-op.
  localparam logic [1:0] REQ_UNKNOWN = 2'd3;

  typedef struct packed {
    logic [15:0] hit_mask;
    logic        taken;
    logic [31:0] count;
    logic [31:0] total;
  } locality_result_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_index;
  logic [4:0]  cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;   // [31:0] address, [35:32] distance_index, [39:36] zero
  logic [1:0]  in_tuser;   // [1:0] req_type
  logic        out_tvalid;
  logic        out_tready;
  logic [87:0] out_tdata;  // [15:0] hit_mask, [16] sample_taken, [48:17] counter_value,
                           // [80:49] total_samples, [87:81] zero

  // Shadow state of the block
  logic [4:0]  shift_cfg;
  logic [3:0]  depth_cfg;
  logic [31:0] hist_pages [SLOTS];
  logic [31:0] dist_hits [SLOTS];
  logic [31:0] sample_total;

  locality_result_t pending_results [$];
  locality_result_t next_result;
  locality_result_t want;

  logic [31:0] page_pool [8];
  int          pool_n;

  int errors;
  int stall_cycles;
  int n_items, n_taken, n_reads, n_clears, n_hit_results, n_settings;

  // Sender and receiver pacing
  bit       steady_tx;
  bit       steady_rx;
  int       burst_left;
  int       rx_hold_len;
  bit [7:0] rx_pattern;
  int       rx_phase;

  page_locality_distance_counter_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  function automatic void clear_locality();
    int i;
    for (i = 0; i < SLOTS; i++) begin
      hist_pages[i] = '0;
      dist_hits[i] = '0;
    end
    sample_total = '0;
  endfunction

  function automatic locality_result_t predict_locality(input logic [1:0] req,
                                                        input logic [31:0] addr,
                                                        input logic [3:0] idx);
    locality_result_t r;
    logic [31:0] page;
    int top;
    int i;
    r = '0;
    case (req)
      pldc_pkg::REQ_SAMPLE: begin
        if (addr != 32'h0 && !addr[31]) begin
          page = addr >> shift_cfg;
          top = (depth_cfg > SLOTS - 1) ? SLOTS - 1 : depth_cfg;
          // shift the history up, comparing each slot after it moves
          for (i = top - 1; i > 0; i--) begin
            hist_pages[i] = hist_pages[i - 1];
            if (hist_pages[i] == page) begin
              if (dist_hits[i] != 32'hFFFF_FFFF) dist_hits[i] = dist_hits[i] + 1;
              r.hit_mask[i] = 1'b1;
            end
          end
          hist_pages[0] = page;
          if (sample_total != 32'hFFFF_FFFF) sample_total = sample_total + 1;
          r.taken = 1'b1;
        end
      end
      pldc_pkg::REQ_READ: begin
        r.count = dist_hits[idx];
      end
      pldc_pkg::REQ_CLEAR: begin
        clear_locality();
      end
      default: begin
      end
    endcase
    r.total = sample_total;
    return r;
  endfunction

  // Predict at the accepting edge, from the beat the block took
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      next_result = predict_locality(in_tuser, in_tdata[31:0], in_tdata[35:32]);
      pending_results.push_back(next_result);
      n_items++;
      if (next_result.taken) n_taken++;
      if (next_result.hit_mask != '0) n_hit_results++;
      if (in_tuser == pldc_pkg::REQ_READ) n_reads++;
      if (in_tuser == pldc_pkg::REQ_CLEAR) n_clears++;
    end
  end

  task automatic compare_field(input string label, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      if (errors < MAX_REPORTS)
        $display("%0t: %s mismatch, expected %h, actual %h", $time, label, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        if (errors < MAX_REPORTS)
          $display("%0t: result beat with nothing expected, expected none, actual %h",
                   $time, out_tdata);
        errors++;
      end else begin
        want = pending_results.pop_front();
        compare_field("hit_mask", 32'(want.hit_mask), 32'(out_tdata[15:0]));
        compare_field("sample_taken", 32'(want.taken), 32'(out_tdata[16]));
        compare_field("counter_value", want.count, out_tdata[48:17]);
        compare_field("total_samples", want.total, out_tdata[80:49]);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles, %0d results outstanding",
                 $time, stall_cycles, pending_results.size());
        $display("page_locality_distance_counter_top_test failed");
        $finish;
      end
    end
  end

  // Receiver: stall pattern, steady mode, or a long hold-off on request
  initial begin : rx_side
    out_tready = 1'b0;
    rx_pattern = 8'b1011_0111;
    rx_phase = 0;
    forever begin
      @(posedge clk);
      if (rx_hold_len > 0) begin
        out_tready <= 1'b0;
        repeat (rx_hold_len) @(posedge clk);
        rx_hold_len = 0;
      end
      if (steady_rx) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= rx_pattern[rx_phase];
        rx_phase = (rx_phase + 1) % 8;
        if (rx_phase == 0) rx_pattern = 8'($urandom) | 8'h01;
      end
    end
  end

  // Leaves in_tvalid high after the accepting edge; caller lowers or sends again.
  task automatic send_item(input logic [1:0] req, input logic [31:0] addr,
                           input logic [3:0] idx);
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {4'b0, idx, addr};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic pace_sender();
    int gap;
    if (!steady_tx) begin
      burst_left--;
      if (burst_left <= 0) begin
        burst_left = $urandom_range(1, 24);
        gap = $urandom_range(0, 9);
        if (gap > 0) begin
          in_tvalid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  endtask

  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Only called with the block idle.
  task automatic program_regs(input logic [4:0] shift, input logic [3:0] depth);
    cfg_we    <= 1'b1;
    cfg_index <= pldc_pkg::CFG_PAGE_SHIFT;
    cfg_wdata <= shift;
    @(posedge clk);
    cfg_index <= pldc_pkg::CFG_HIST_DEPTH;
    cfg_wdata <= {1'b0, depth};
    @(posedge clk);
    cfg_we <= 1'b0;
    shift_cfg = shift;
    depth_cfg = depth;
    n_settings++;
  endtask

  task automatic test_special_cases();
    steady_tx = 1'b1;
    steady_rx = 1'b0;
    // ignored addresses: zero and bit 31 set
    send_item(pldc_pkg::REQ_SAMPLE, 32'h0000_0000, 4'd0);
    send_item(pldc_pkg::REQ_SAMPLE, 32'h8000_0000, 4'd15);
    send_item(pldc_pkg::REQ_SAMPLE, 32'hFFFF_FFFF, 4'd0);
    // page 0 hits the zeroed history slots
    send_item(pldc_pkg::REQ_SAMPLE, 32'h0000_0FFF, 4'd0);
    send_item(pldc_pkg::REQ_SAMPLE, 32'h7FFF_FFFF, 4'd0);
    send_item(pldc_pkg::REQ_SAMPLE, 32'h0000_1000, 4'd0);
    send_item(pldc_pkg::REQ_SAMPLE, 32'h0000_1FFF, 4'd0);
    send_item(pldc_pkg::REQ_READ, 32'h0, 4'd1);
    send_item(pldc_pkg::REQ_READ, 32'hFFFF_FFFF, 4'd0);   // slot 0 never counts
    send_item(pldc_pkg::REQ_READ, 32'h0, 4'd15);
    send_item(REQ_UNKNOWN, 32'hFFFF_FFFF, 4'd15);
    send_item(pldc_pkg::REQ_CLEAR, 32'h0, 4'd0);
    send_item(pldc_pkg::REQ_READ, 32'h0, 4'd1);
    wait_for_results();
  endtask

  task automatic test_config_extremes();
    // depth one: nothing compared, slot 0 still loads
    program_regs(5'd0, 4'd1);
    send_item(pldc_pkg::REQ_SAMPLE, 32'h0000_0005, 4'd0);
    send_item(pldc_pkg::REQ_SAMPLE, 32'h0000_0005, 4'd0);
    send_item(pldc_pkg::REQ_READ, 32'h0, 4'd1);
    wait_for_results();
    // widest shift folds every legal address onto page 0
    program_regs(5'd31, 4'd15);
    send_item(pldc_pkg::REQ_SAMPLE, 32'h7FFF_FFFF, 4'd0);
    send_item(pldc_pkg::REQ_SAMPLE, 32'h4000_0000, 4'd0);
    send_item(pldc_pkg::REQ_SAMPLE, 32'h0000_0001, 4'd0);
    send_item(pldc_pkg::REQ_READ, 32'h0, 4'd14);
    wait_for_results();
    program_regs(5'd0, 4'd0);
    send_item(pldc_pkg::REQ_SAMPLE, 32'h0000_0007, 4'd0);
    send_item(pldc_pkg::REQ_SAMPLE, 32'h0000_0007, 4'd0);
    send_item(pldc_pkg::REQ_READ, 32'h0, 4'd0);
    wait_for_results();
  endtask

  task automatic send_random_item();
    int roll;
    logic [31:0] addr;
    logic [31:0] low_mask;
    roll = $urandom_range(0, 99);
    addr = $urandom;
    low_mask = ~(32'hFFFF_FFFF << shift_cfg);
    if (roll < 70) begin
      addr = ((page_pool[$urandom_range(0, pool_n - 1)] << shift_cfg) | (addr & low_mask))
             & 32'h7FFF_FFFF;
      send_item(pldc_pkg::REQ_SAMPLE, addr, 4'($urandom));
    end else if (roll < 73) begin
      send_item(pldc_pkg::REQ_SAMPLE, 32'h0, 4'($urandom));
    end else if (roll < 79) begin
      send_item(pldc_pkg::REQ_SAMPLE, addr | 32'h8000_0000, 4'($urandom));
    end else if (roll < 90) begin
      send_item(pldc_pkg::REQ_READ, addr, 4'($urandom));
    end else if (roll < 92) begin
      send_item(pldc_pkg::REQ_CLEAR, addr, 4'($urandom));
    end else if (roll < 95) begin
      send_item(REQ_UNKNOWN, addr, 4'($urandom));
    end else begin
      send_item(pldc_pkg::REQ_SAMPLE, addr & 32'h7FFF_FFFF, 4'($urandom));
    end
    pace_sender();
  endtask

  task automatic test_random_traffic();
    int phase;
    int k;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      program_regs(5'($urandom_range(0, 31)), 4'($urandom_range(0, 15)));
      // a few hot pages so that distances actually recur
      pool_n = $urandom_range(1, 8);
      for (k = 0; k < pool_n; k++) begin
        page_pool[k] = ($urandom_range(0, 3) == 0) ? 32'h0
                       : ($urandom & (32'h7FFF_FFFF >> shift_cfg));
      end
      steady_tx = ($urandom_range(0, 3) == 0);
      steady_rx = ($urandom_range(0, 3) == 0);
      burst_left = $urandom_range(1, 24);
      for (k = 0; k < PHASE_ITEMS; k++) send_random_item();
      wait_for_results();
    end
  endtask

  task automatic test_backpressure();
    int k;
    steady_tx = 1'b1;
    steady_rx = 1'b0;
    pool_n = 2;
    page_pool[0] = 32'h3;
    page_pool[1] = 32'h0;
    rx_hold_len = HOLD_OFF_LEN;
    for (k = 0; k < 30; k++) send_random_item();
    wait_for_results();
  endtask

  initial begin
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = pldc_pkg::CFG_PAGE_SHIFT;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = pldc_pkg::REQ_SAMPLE;
    errors = 0;
    stall_cycles = 0;
    steady_tx = 1'b1;
    steady_rx = 1'b1;
    burst_left = 1;
    rx_hold_len = 0;
    pool_n = 1;
    page_pool[0] = '0;
    shift_cfg = pldc_pkg::PAGE_SHIFT_RST;
    depth_cfg = pldc_pkg::HIST_DEPTH_RST;
    clear_locality();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_special_cases();
    test_config_extremes();
    test_random_traffic();
    test_backpressure();

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Covered %0d items: %0d samples taken, %0d counter reads, %0d clears.",
             n_items, n_taken, n_reads, n_clears);
    $display("%0d results showed slot hits over %0d register settings.",
             n_hit_results, n_settings);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("page_locality_distance_counter_top_test passed");
    end else begin
      $display("page_locality_distance_counter_top_test failed");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/pldc_pkg.sv
rtl/pldc_history.sv
rtl/pldc_counters.sv
rtl/page_locality_distance_counter_top.sv
tb/page_locality_distance_counter_top_test.sv
